// ===== sv/tdw_pkg.sv =====
// Track drive wheel command: shared widths, constants and register codes.
// No dependencies; compiled first.
package tdw_pkg;

  localparam int VEL_W      = 20;  // Q4.16 body command fields
  localparam int HTW_W      = 20;  // half track width, Q4.16
  localparam int GAIN_W     = 24;  // speed gain, Q8.16
  localparam int DB_W       = 16;  // deadband, Q1.15
  localparam int CORR_W     = 16;  // wheel correction, Q2.14
  localparam int CMD_W      = 18;  // wheel command, Q3.15
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_TRACK_WIDTH = 3'd0,
    CFG_SPEED_GAIN       = 3'd1,
    CFG_DEADBAND         = 3'd2,
    CFG_CORR_LEFT_A      = 3'd3,
    CFG_CORR_LEFT_B      = 3'd4,
    CFG_CORR_RIGHT_A     = 3'd5,
    CFG_CORR_RIGHT_B     = 3'd6
  } cfg_idx_e;

  localparam logic [HTW_W-1:0]  HTW_RST  = 20'd17695;
  localparam logic [GAIN_W-1:0] GAIN_RST = 24'd54939;
  localparam logic [DB_W-1:0]   DB_RST   = 16'd655;
  localparam logic [CORR_W-1:0] CORR_RST = 16'd16384;

endpackage

// ===== sv/tdw_if.sv =====
// Channel interfaces: body command in, wheel commands out, register writes.
// Depends on tdw_pkg.
interface tdw_cmd_if;
  logic                              valid;
  logic                              ready;
  logic signed [tdw_pkg::VEL_W-1:0] linear_vel;
  logic signed [tdw_pkg::VEL_W-1:0] yaw_rate;

  modport source (output valid, linear_vel, yaw_rate, input ready);
  modport sink   (input valid, linear_vel, yaw_rate, output ready);
endinterface

interface tdw_whl_if;
  logic                              valid;
  logic                              ready;
  logic signed [tdw_pkg::CMD_W-1:0] left_a_cmd;
  logic signed [tdw_pkg::CMD_W-1:0] left_b_cmd;
  logic signed [tdw_pkg::CMD_W-1:0] right_a_cmd;
  logic signed [tdw_pkg::CMD_W-1:0] right_b_cmd;

  modport source (output valid, left_a_cmd, left_b_cmd, right_a_cmd, right_b_cmd,
                  input ready);
  modport sink   (input valid, left_a_cmd, left_b_cmd, right_a_cmd, right_b_cmd,
                  output ready);
endinterface

interface tdw_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tdw_pkg::CFG_IDX_W-1:0]      index;
  logic [tdw_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/track_drive_wheel_command_top.sv =====
// Channel | dir | payload                                         | handshake
// cfg_i   | in  | index (3b), data (24b)                          | valid/ready
// cmd_i   | in  | linear_vel, yaw_rate (s20 Q4.16)                | valid/ready
// whl_o   | out | left_a/b_cmd, right_a/b_cmd (s18 Q3.15, sat.)   | valid/ready
//
// One command is accepted per cycle while the pipe is not held. The depth is set by
// the normalizing divider: one quotient bit per stage, 16 stages.
// The whole pipe advances as one; it holds when the output stage is full
// and not taken, so cmd_i.ready follows whl_o.ready combinationally.
// Reset clears the valid bits and loads the register defaults.
// Config writes are always ready and take effect on the next cycle.
// Track drive wheel command top: differential-drive inverse kinematics.
// Depends on tdw_pkg and tdw_if.
module track_drive_wheel_command_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  tdw_cfg_if.sink   cfg_i,
  tdw_cmd_if.sink   cmd_i,
  tdw_whl_if.source whl_o
);
  import tdw_pkg::*;

  // Internal widths
  localparam int TURN_W    = VEL_W + HTW_W + 1;  // yaw * half width, signed
  localparam int SUM_W     = TURN_W + 1;         // v*2^16 -/+ turn, signed
  localparam int SPD_W     = 25;                 // rounded |speed|, Q.16
  localparam int NRM_W     = SPD_W + GAIN_W;     // |speed| * gain, Q.32
  localparam int NUM_W     = NRM_W + 17;         // divider numerator
  localparam int Q_W       = 16;                 // Q1.15 side magnitude
  localparam int DIV_STEPS = Q_W;
  localparam int NSTG      = DIV_STEPS + 6;
  localparam logic [NRM_W-1:0] ONE_Q32 = NRM_W'(64'h1_0000_0000);

  // Divider stage payload: both sides share the divisor (larger side)
  typedef struct packed {
    logic [NRM_W-1:0] big;
    logic [NRM_W-1:0] rem_l;
    logic [NRM_W-1:0] rem_r;
    logic [Q_W-1:0]   lo_l;
    logic [Q_W-1:0]   lo_r;
    logic [Q_W-1:0]   q_l;
    logic [Q_W-1:0]   q_r;
    logic [Q_W-1:0]   sm_l;   // unnormalized rounding result
    logic [Q_W-1:0]   sm_r;
    logic             norm;
    logic             neg_l;
    logic             neg_r;
  } div_t;

  // ---------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------
  function automatic logic [SPD_W-1:0] round16(logic [SUM_W-1:0] m);
    logic [SUM_W:0] t;
    t = {1'b0, m} + (SUM_W+1)'(32768);
    return t[16 +: SPD_W];
  endfunction

  // one restoring step per side
  function automatic div_t div_step(div_t s);
    div_t         r;
    logic [NRM_W:0] tl;
    logic [NRM_W:0] tr;
    r  = s;
    tl = {s.rem_l, s.lo_l[Q_W-1]};
    tr = {s.rem_r, s.lo_r[Q_W-1]};
    r.lo_l = {s.lo_l[Q_W-2:0], 1'b0};
    r.lo_r = {s.lo_r[Q_W-2:0], 1'b0};
    if (tl >= {1'b0, s.big}) begin
      tl    = tl - {1'b0, s.big};
      r.q_l = {s.q_l[Q_W-2:0], 1'b1};
    end else begin
      r.q_l = {s.q_l[Q_W-2:0], 1'b0};
    end
    if (tr >= {1'b0, s.big}) begin
      tr    = tr - {1'b0, s.big};
      r.q_r = {s.q_r[Q_W-2:0], 1'b1};
    end else begin
      r.q_r = {s.q_r[Q_W-2:0], 1'b0};
    end
    r.rem_l = tl[NRM_W-1:0];
    r.rem_r = tr[NRM_W-1:0];
    return r;
  endfunction

  // side * correction, rounded to Q3.15; negative side halved in the rounding
  function automatic logic signed [CMD_W-1:0] wheel_cmd(logic neg, logic [Q_W-1:0] mag,
                                                        logic [CORR_W-1:0] corr);
    logic [Q_W+CORR_W-1:0]   p;
    logic [Q_W+CORR_W:0]     t;
    logic [CMD_W:0]          r;
    logic signed [CMD_W+1:0] s;
    p = (Q_W+CORR_W)'(mag) * (Q_W+CORR_W)'(corr);
    if (neg) begin
      t = {1'b0, p} + (Q_W+CORR_W+1)'(16384);
      r = {1'b0, t[15 +: CMD_W]};
      s = -$signed({1'b0, r});
    end else begin
      t = {1'b0, p} + (Q_W+CORR_W+1)'(8192);
      r = t[14 +: CMD_W+1];
      s = $signed({1'b0, r});
    end
    if (s > (CMD_W+2)'(131071)) begin
      s = (CMD_W+2)'(131071);
    end else if (s < -(CMD_W+2)'(131072)) begin
      s = -(CMD_W+2)'(131072);
    end
    return s[CMD_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [HTW_W-1:0]  htw_q;
  logic [GAIN_W-1:0] gain_q;
  logic [DB_W-1:0]   db_q;
  logic [CORR_W-1:0] corr_la_q, corr_lb_q, corr_ra_q, corr_rb_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      htw_q     <= HTW_RST;
      gain_q    <= GAIN_RST;
      db_q      <= DB_RST;
      corr_la_q <= CORR_RST;
      corr_lb_q <= CORR_RST;
      corr_ra_q <= CORR_RST;
      corr_rb_q <= CORR_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_HALF_TRACK_WIDTH: htw_q     <= cfg_i.data[HTW_W-1:0];
        CFG_SPEED_GAIN:       gain_q    <= cfg_i.data[GAIN_W-1:0];
        CFG_DEADBAND:         db_q      <= cfg_i.data[DB_W-1:0];
        CFG_CORR_LEFT_A:      corr_la_q <= cfg_i.data[CORR_W-1:0];
        CFG_CORR_LEFT_B:      corr_lb_q <= cfg_i.data[CORR_W-1:0];
        CFG_CORR_RIGHT_A:     corr_ra_q <= cfg_i.data[CORR_W-1:0];
        CFG_CORR_RIGHT_B:     corr_rb_q <= cfg_i.data[CORR_W-1:0];
        default: ;  // unused index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: one enable for every stage
  // ---------------------------------------------------------------------
  logic            adv;
  logic [NSTG-1:0] vld_q;

  assign adv         = !vld_q[NSTG-1] || whl_o.ready;
  assign cmd_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], cmd_i.valid};
    end
  end

  // Stage A: turn term yaw * half width
  logic signed [VEL_W-1:0]  a_v_q;
  logic signed [TURN_W-1:0] a_turn_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_v_q    <= cmd_i.linear_vel;
      a_turn_q <= TURN_W'(cmd_i.yaw_rate) * TURN_W'($signed({1'b0, htw_q}));
    end
  end

  // Stage B: track speeds, sign and magnitude rounded to Q.16
  logic signed [SUM_W-1:0] b_lq, b_rq;
  logic [SUM_W-1:0]        b_lm, b_rm;
  logic                    b_lneg_q, b_rneg_q;
  logic [SPD_W-1:0]        b_l16_q, b_r16_q;

  always_comb begin
    b_lq = (SUM_W'(a_v_q) <<< 16) - SUM_W'(a_turn_q);
    b_rq = (SUM_W'(a_v_q) <<< 16) + SUM_W'(a_turn_q);
    b_lm = b_lq[SUM_W-1] ? SUM_W'(-b_lq) : SUM_W'(b_lq);
    b_rm = b_rq[SUM_W-1] ? SUM_W'(-b_rq) : SUM_W'(b_rq);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_lneg_q <= b_lq[SUM_W-1];
      b_rneg_q <= b_rq[SUM_W-1];
      b_l16_q  <= round16(b_lm);
      b_r16_q  <= round16(b_rm);
    end
  end

  // Stage C: scale by gain to Q.32
  logic [NRM_W-1:0] c_ln_q, c_rn_q;
  logic             c_lneg_q, c_rneg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_ln_q   <= NRM_W'(b_l16_q) * NRM_W'(gain_q);
      c_rn_q   <= NRM_W'(b_r16_q) * NRM_W'(gain_q);
      c_lneg_q <= b_lneg_q;
      c_rneg_q <= b_rneg_q;
    end
  end

  // Stage D: pick the larger side, set up the divider and the plain rounding
  logic [NRM_W-1:0] d_big;
  logic [NUM_W-1:0] d_num_l, d_num_r;
  logic [NRM_W:0]   d_sm_l, d_sm_r;
  div_t             div_q [DIV_STEPS+1];

  always_comb begin
    d_big   = (c_ln_q > c_rn_q) ? c_ln_q : c_rn_q;
    d_num_l = (NUM_W'(c_ln_q) << 15) + NUM_W'(d_big >> 1);
    d_num_r = (NUM_W'(c_rn_q) << 15) + NUM_W'(d_big >> 1);
    d_sm_l  = {1'b0, c_ln_q} + (NRM_W+1)'(65536);
    d_sm_r  = {1'b0, c_rn_q} + (NRM_W+1)'(65536);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0].big   <= d_big;
      div_q[0].rem_l <= d_num_l[16 +: NRM_W];  // below divisor by construction
      div_q[0].rem_r <= d_num_r[16 +: NRM_W];
      div_q[0].lo_l  <= d_num_l[Q_W-1:0];
      div_q[0].lo_r  <= d_num_r[Q_W-1:0];
      div_q[0].q_l   <= '0;
      div_q[0].q_r   <= '0;
      div_q[0].sm_l  <= d_sm_l[17 +: Q_W];
      div_q[0].sm_r  <= d_sm_r[17 +: Q_W];
      div_q[0].norm  <= d_big > ONE_Q32;
      div_q[0].neg_l <= c_lneg_q;
      div_q[0].neg_r <= c_rneg_q;
    end
  end

  // Divider: one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[k+1] <= div_step(div_q[k]);
      end
    end
  end

  // Stage E: select normalized or plain result, apply deadband
  logic [Q_W-1:0] e_lsel, e_rsel, e_lm, e_rm;
  logic [Q_W-1:0] e_lm_q, e_rm_q;
  logic           e_lneg_q, e_rneg_q;

  always_comb begin
    e_lsel = div_q[DIV_STEPS].norm ? div_q[DIV_STEPS].q_l : div_q[DIV_STEPS].sm_l;
    e_rsel = div_q[DIV_STEPS].norm ? div_q[DIV_STEPS].q_r : div_q[DIV_STEPS].sm_r;
    e_lm   = (e_lsel < db_q) ? '0 : e_lsel;
    e_rm   = (e_rsel < db_q) ? '0 : e_rsel;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_lm_q   <= e_lm;
      e_rm_q   <= e_rm;
      e_lneg_q <= div_q[DIV_STEPS].neg_l && (e_lm != '0);
      e_rneg_q <= div_q[DIV_STEPS].neg_r && (e_rm != '0);
    end
  end

  // Stage F: per-wheel correction, output register
  logic signed [CMD_W-1:0] f_la_q, f_lb_q, f_ra_q, f_rb_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_la_q <= wheel_cmd(e_lneg_q, e_lm_q, corr_la_q);
      f_lb_q <= wheel_cmd(e_lneg_q, e_lm_q, corr_lb_q);
      f_ra_q <= wheel_cmd(e_rneg_q, e_rm_q, corr_ra_q);
      f_rb_q <= wheel_cmd(e_rneg_q, e_rm_q, corr_rb_q);
    end
  end

  assign whl_o.valid       = vld_q[NSTG-1];
  assign whl_o.left_a_cmd  = f_la_q;
  assign whl_o.left_b_cmd  = f_lb_q;
  assign whl_o.right_a_cmd = f_ra_q;
  assign whl_o.right_b_cmd = f_rb_q;

endmodule

// ===== sv/tdw_chk.sv =====
// Port-level checks for the track drive wheel command block, plus its bind.
// Depends on tdw_pkg and track_drive_wheel_command_top.
module tdw_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cmd_ready_i,
  input logic                             whl_valid_i,
  input logic                             whl_ready_i,
  input logic signed [tdw_pkg::CMD_W-1:0] left_a_i,
  input logic signed [tdw_pkg::CMD_W-1:0] left_b_i,
  input logic signed [tdw_pkg::CMD_W-1:0] right_a_i,
  input logic signed [tdw_pkg::CMD_W-1:0] right_b_i
);
  import tdw_pkg::*;

  // a halved negative command never goes below -2^16
  localparam logic signed [CMD_W-1:0] NEG_FLOOR = -(CMD_W'(65536));

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    whl_valid_i && !whl_ready_i |=> whl_valid_i && $stable(left_a_i) &&
      $stable(right_b_i))
    else $error("stalled wheel transaction changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !whl_valid_i || whl_ready_i |-> cmd_ready_i)
    else $error("command stalled while output free");

  a_lsign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    whl_valid_i |-> !(left_a_i < 0 && left_b_i > 0) && !(left_a_i > 0 && left_b_i < 0))
    else $error("left wheels disagree in sign");

  a_rsign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    whl_valid_i |-> !(right_a_i < 0 && right_b_i > 0) &&
      !(right_a_i > 0 && right_b_i < 0))
    else $error("right wheels disagree in sign");

  a_negbnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    whl_valid_i |-> left_a_i >= NEG_FLOOR && left_b_i >= NEG_FLOOR &&
      right_a_i >= NEG_FLOOR && right_b_i >= NEG_FLOOR)
    else $error("negative command not halved");

endmodule

bind track_drive_wheel_command_top tdw_chk u_tdw_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_ready_i (cmd_i.ready),
  .whl_valid_i (whl_o.valid),
  .whl_ready_i (whl_o.ready),
  .left_a_i    (whl_o.left_a_cmd),
  .left_b_i    (whl_o.left_b_cmd),
  .right_a_i   (whl_o.right_a_cmd),
  .right_b_i   (whl_o.right_b_cmd)
);

// ===== tb/track_drive_wheel_command_checker.sv =====
// Checker for the track drive wheel command block: watches the register,
// command and wheel channels, predicts each wheel command set and compares it.
// Depends on tdw_pkg and the channel interfaces in tdw_if.
`timescale 1ns / 100ps

module track_drive_wheel_command_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tdw_cfg_if   cfg_mon,
  tdw_cmd_if   cmd_mon,
  tdw_whl_if   whl_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);
  import tdw_pkg::*;

  localparam longint unsigned NORM_ONE  = 64'h1_0000_0000;  // 1.0 in Q.32
  localparam longint          WHEEL_MAX = 131071;
  localparam longint          WHEEL_MIN = -131072;

  typedef struct packed {
    logic signed [CMD_W-1:0] left_a;
    logic signed [CMD_W-1:0] left_b;
    logic signed [CMD_W-1:0] right_a;
    logic signed [CMD_W-1:0] right_b;
  } wheel_cmds_t;

  logic [HTW_W-1:0]  half_track_q;
  logic [GAIN_W-1:0] speed_gain_q;
  logic [DB_W-1:0]   deadband_q;
  logic [CORR_W-1:0] corr_left_a_q, corr_left_b_q, corr_right_a_q, corr_right_b_q;

  wheel_cmds_t expected_wheels [$];
  int          mismatches = 0;
  int          wheel_sets = 0;

  // Registers change in the cycle after the write, same as the block.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_track_q   <= HTW_RST;
      speed_gain_q   <= GAIN_RST;
      deadband_q     <= DB_RST;
      corr_left_a_q  <= CORR_RST;
      corr_left_b_q  <= CORR_RST;
      corr_right_a_q <= CORR_RST;
      corr_right_b_q <= CORR_RST;
    end else if (cfg_mon.valid && cfg_mon.ready) begin
      case (cfg_mon.index)
        CFG_HALF_TRACK_WIDTH: half_track_q   <= cfg_mon.data[HTW_W-1:0];
        CFG_SPEED_GAIN:       speed_gain_q   <= cfg_mon.data[GAIN_W-1:0];
        CFG_DEADBAND:         deadband_q     <= cfg_mon.data[DB_W-1:0];
        CFG_CORR_LEFT_A:      corr_left_a_q  <= cfg_mon.data[CORR_W-1:0];
        CFG_CORR_LEFT_B:      corr_left_b_q  <= cfg_mon.data[CORR_W-1:0];
        CFG_CORR_RIGHT_A:     corr_right_a_q <= cfg_mon.data[CORR_W-1:0];
        CFG_CORR_RIGHT_B:     corr_right_b_q <= cfg_mon.data[CORR_W-1:0];
        default: ;
      endcase
    end
  end

  // Q1.15 side times Q2.14 correction; reverse drive is halved in the same rounding.
  function automatic logic signed [CMD_W-1:0] scale_wheel(logic negative,
                                                          longint unsigned mag,
                                                          logic [CORR_W-1:0] corr);
    longint unsigned prod;
    longint          cmd;
    prod = mag * corr;
    if (negative) cmd = -longint'((prod + 64'd16384) >> 15);
    else          cmd = longint'((prod + 64'd8192) >> 14);
    if (cmd > WHEEL_MAX) cmd = WHEEL_MAX;
    if (cmd < WHEEL_MIN) cmd = WHEEL_MIN;
    return cmd[CMD_W-1:0];
  endfunction

  function automatic wheel_cmds_t predict_wheels(logic signed [VEL_W-1:0] lin,
                                                 logic signed [VEL_W-1:0] yaw);
    longint          turn;
    longint          speed_q32 [2];
    logic            negative [2];
    longint unsigned norm [2];
    longint unsigned mag [2];
    longint unsigned larger;
    int              side;
    wheel_cmds_t     cmds;
    turn = longint'(yaw) * longint'(half_track_q);
    speed_q32[0] = longint'(lin) * 65536 - turn;
    speed_q32[1] = longint'(lin) * 65536 + turn;
    for (side = 0; side < 2; side++) begin
      negative[side] = speed_q32[side] < 0;
      mag[side]  = negative[side] ? -speed_q32[side] : speed_q32[side];
      norm[side] = ((mag[side] + 64'd32768) >> 16) * speed_gain_q;
    end
    larger = (norm[0] > norm[1]) ? norm[0] : norm[1];
    for (side = 0; side < 2; side++) begin
      // above 1.0 the larger side is pinned to exactly 1.0
      if (larger > NORM_ONE) mag[side] = ((norm[side] << 15) + (larger >> 1)) / larger;
      else                   mag[side] = (norm[side] + 64'd65536) >> 17;
      if (mag[side] < deadband_q) mag[side] = 0;
      if (mag[side] == 0) negative[side] = 1'b0;
    end
    cmds.left_a  = scale_wheel(negative[0], mag[0], corr_left_a_q);
    cmds.left_b  = scale_wheel(negative[0], mag[0], corr_left_b_q);
    cmds.right_a = scale_wheel(negative[1], mag[1], corr_right_a_q);
    cmds.right_b = scale_wheel(negative[1], mag[1], corr_right_b_q);
    return cmds;
  endfunction

  function automatic int check_field(string name, logic signed [CMD_W-1:0] exp_val,
                                     logic signed [CMD_W-1:0] act_val);
    if (exp_val === act_val) return 0;
    $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
    return 1;
  endfunction

  always @(posedge clk_i) begin
    wheel_cmds_t exp_cmds;
    if (whl_mon.valid && whl_mon.ready) begin
      if (expected_wheels.size() == 0) begin
        $error("wheel command transaction with no body command pending");
        mismatches++;
      end else begin
        exp_cmds = expected_wheels.pop_front();
        mismatches += check_field("left_a_cmd", exp_cmds.left_a, whl_mon.left_a_cmd);
        mismatches += check_field("left_b_cmd", exp_cmds.left_b, whl_mon.left_b_cmd);
        mismatches += check_field("right_a_cmd", exp_cmds.right_a, whl_mon.right_a_cmd);
        mismatches += check_field("right_b_cmd", exp_cmds.right_b, whl_mon.right_b_cmd);
        wheel_sets++;
      end
    end
    if (cmd_mon.valid && cmd_mon.ready)
      expected_wheels.push_back(predict_wheels(cmd_mon.linear_vel, cmd_mon.yaw_rate));
    fail_count_o <= mismatches;
    pending_o    <= expected_wheels.size();
    checked_o    <= wheel_sets;
  end

endmodule

// ===== tb/track_drive_wheel_command_top_test.sv =====
// Testbench top for track_drive_wheel_command_top: drives register writes and
// body commands, stalls the wheel side, and gives the verdict.
// Depends on tdw_pkg, tdw_if and track_drive_wheel_command_checker.
`timescale 1ns / 100ps

module track_drive_wheel_command_top_test;
  import tdw_pkg::*;

  localparam int PIPE_LATENCY   = 22;
  localparam int DRAIN_CYCLES   = PIPE_LATENCY + 10;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int LONG_STALL     = 120;   // much deeper than the pipe, so the input backs up
  localparam int PHASE_COMMANDS = 230;
  localparam int NUM_PHASES     = 8;

  // index with no register behind it; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  localparam logic signed [VEL_W-1:0] VEL_MAX = 20'sh7FFFF;
  localparam logic signed [VEL_W-1:0] VEL_MIN = 20'sh80000;
  localparam logic signed [VEL_W-1:0] ONE_MPS = 20'sh10000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tdw_cfg_if cfg_bus ();
  tdw_cmd_if cmd_bus ();
  tdw_whl_if whl_bus ();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_left     = 0;
  int cycle_count    = 0;
  int commands_sent  = 0;
  int settings_used  = 0;
  int fail_count;
  int pending_cmds;
  int wheels_checked;

  track_drive_wheel_command_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .cmd_i  (cmd_bus),
    .whl_o  (whl_bus)
  );

  track_drive_wheel_command_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_bus),
    .cmd_mon      (cmd_bus),
    .whl_mon      (whl_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending_cmds),
    .checked_o    (wheels_checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Every input known from time zero.
  initial begin
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = '0;
    cfg_bus.data       = '0;
    cmd_bus.valid      = 1'b0;
    cmd_bus.linear_vel = '0;
    cmd_bus.yaw_rate   = '0;
    whl_bus.ready      = 1'b0;
  end

  // Long receiver hold-off, counted here; the main flow only loads it while it is zero.
  always @(posedge clk_i) begin
    if (stall_left != 0) stall_left <= stall_left - 1;
  end

  // Wheel side: random stalls at the phase's rate, nothing during a hold-off.
  always @(posedge clk_i) begin
    whl_bus.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // Hang guard: a run that is still going here has lost transactions.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("track_drive_wheel_command_top_test NOT OK");
    $finish;
  end

  // One register write; the caller drops valid after its last write.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
  endtask

  // Drop command valid and let every wheel set come out, then let the pipe go quiet.
  task automatic wait_idle();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cmds != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [HTW_W-1:0] half_track, logic [GAIN_W-1:0] gain,
                                logic [DB_W-1:0] deadband,
                                logic [CORR_W-1:0] corr_la, logic [CORR_W-1:0] corr_lb,
                                logic [CORR_W-1:0] corr_ra, logic [CORR_W-1:0] corr_rb);
    wait_idle();
    write_register(CFG_HALF_TRACK_WIDTH, CFG_DATA_W'(half_track));
    write_register(CFG_SPEED_GAIN, CFG_DATA_W'(gain));
    write_register(CFG_DEADBAND, CFG_DATA_W'(deadband));
    write_register(CFG_CORR_LEFT_A, CFG_DATA_W'(corr_la));
    write_register(CFG_CORR_LEFT_B, CFG_DATA_W'(corr_lb));
    write_register(CFG_CORR_RIGHT_A, CFG_DATA_W'(corr_ra));
    write_register(CFG_CORR_RIGHT_B, CFG_DATA_W'(corr_rb));
    cfg_bus.valid <= 1'b0;
    settings_used++;
  endtask

  // Random setting: track widths and gains spread over many octaves,
  // corrections mostly near 1.0, deadband mostly in a plausible range.
  task automatic random_settings();
    logic [HTW_W-1:0]  half_track;
    logic [GAIN_W-1:0] gain;
    logic [DB_W-1:0]   deadband;
    logic [CORR_W-1:0] corr [4];
    half_track = HTW_W'($urandom) >> $urandom_range(10);
    gain       = GAIN_W'($urandom) >> $urandom_range(4, 14);
    deadband   = ($urandom_range(7) == 0) ? DB_W'($urandom) : DB_W'($urandom_range(3000));
    foreach (corr[k])
      corr[k] = ($urandom_range(3) == 0) ? CORR_W'($urandom)
                                         : CORR_W'($urandom_range(12000, 20000));
    apply_settings(half_track, gain, deadband, corr[0], corr[1], corr[2], corr[3]);
  endtask

  // One body command; idles first at the phase's rate. Valid stays up for
  // back-to-back commands, so it gets one assignment per edge.
  task automatic send_command(logic signed [VEL_W-1:0] lin, logic signed [VEL_W-1:0] yaw);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.linear_vel <= lin;
    cmd_bus.yaw_rate   <= yaw;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    commands_sent++;
  endtask

  // Mix of full-range noise, octave-scaled values, extremes, everyday speeds
  // (around 1 m/s or rad/s) and near-zero values that probe the deadband.
  function automatic logic signed [VEL_W-1:0] rand_velocity();
    logic signed [VEL_W-1:0] vel;
    vel = VEL_W'($urandom);
    case ($urandom_range(5))
      0:       ;
      1:       vel = vel >>> $urandom_range(4, 19);
      2: begin
        case ($urandom_range(4))
          0:       vel = VEL_MAX;
          1:       vel = VEL_MIN;
          2:       vel = '0;
          3:       vel = 20'sd1;
          default: vel = -20'sd1;
        endcase
      end
      3, 4:    vel = VEL_W'($urandom_range(4 * 65536)) - 20'sh20000;
      default: vel = VEL_W'($urandom_range(4000)) - 20'sd2000;
    endcase
    return vel;
  endfunction

  initial begin
    int phase;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed commands at the reset setting: standstill, full-scale straight
    // runs and spins (normalized to 1.0), mixed corners, an in-range forward
    // speed, reverse with turn (halved), and speeds just under and over the deadband.
    send_command('0, '0);
    send_command(VEL_MAX, '0);
    send_command(VEL_MIN, '0);
    send_command('0, VEL_MAX);
    send_command('0, VEL_MIN);
    send_command(VEL_MAX, VEL_MAX);
    send_command(VEL_MIN, VEL_MIN);
    send_command(VEL_MAX, VEL_MIN);
    send_command(ONE_MPS, '0);
    send_command(-ONE_MPS, 20'sh08000);
    send_command(20'sd500, '0);
    send_command(20'sd2000, '0);
    send_command(20'sd1, -20'sd1);

    // Zero gain: everything must come out zero. Also a write to an unused index.
    apply_settings(HTW_RST, '0, DB_RST, CORR_RST, CORR_RST, CORR_RST, CORR_RST);
    @(posedge clk_i);
    write_register(CFG_IDX_UNUSED, '1);
    cfg_bus.valid <= 1'b0;
    send_command(VEL_MAX, VEL_MIN);
    send_command(ONE_MPS, ONE_MPS);

    // Deadband exactly 1.0 lets only a full-scale side through; above it, nothing.
    apply_settings(HTW_RST, GAIN_RST, 16'd32768, CORR_RST, CORR_RST, CORR_RST, CORR_RST);
    send_command(VEL_MAX, '0);
    send_command(ONE_MPS, '0);
    apply_settings(HTW_RST, GAIN_RST, '1, CORR_RST, CORR_RST, CORR_RST, CORR_RST);
    send_command(VEL_MAX, '0);

    // Widest track, largest gain and corrections: the largest wheel outputs.
    apply_settings('1, '1, '0, '1, '1, '1, '1);
    send_command(VEL_MAX, VEL_MAX);
    send_command(VEL_MIN, VEL_MAX);
    send_command(20'sd1, '0);

    // Random phases; idling cycles through none, sender, receiver, both.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: apply_settings(HTW_RST, GAIN_RST, DB_RST, CORR_RST, CORR_RST, CORR_RST, CORR_RST);
        1: apply_settings('1, '1, '0, '1, '1, '1, '1);
        2: apply_settings('0, GAIN_W'(24'h010000), '0, '0, '0, '0, '0);
        4: apply_settings(HTW_W'($urandom), GAIN_W'($urandom) >> 8, 16'd32768,
                          CORR_RST, CORR_RST, CORR_RST, CORR_RST);
        default: random_settings();
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 77;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 77;
        end
        default: begin
          send_idle_pct  <= 25;
          recv_stall_pct <= 25;
        end
      endcase
      // Back-pressure: the wheel side holds off while commands keep coming.
      if (phase == 0) stall_left <= LONG_STALL;
      repeat (PHASE_COMMANDS) send_command(rand_velocity(), rand_velocity());
    end

    wait_idle();
    if (pending_cmds != 0) $error("%0d wheel command sets never arrived", pending_cmds);

    $display("Covered %0d body commands under %0d register settings, %0d wheel sets checked.",
             commands_sent, settings_used + 1, wheels_checked);
    $display("Idling: none, sender-only, receiver-only, both, plus one long wheel-side hold-off.");
    if (fail_count == 0 && pending_cmds == 0) begin
      $display("track_drive_wheel_command_top_test OK");
    end else begin
      $display("track_drive_wheel_command_top_test NOT OK");
    end
    $finish;
  end

endmodule
